[src/swm_pkg.sv]
// Shared constants and types for the sliding-window maximum unit.
// Depends on nothing; every module of the unit imports it.
package swm_pkg;

    localparam int MAX_WINDOW_DEF = 64;
    localparam int SAMPLE_W       = 32;
    localparam int WSIZE_W        = 7;

    // Per-step control broadcast to every queue cell.
    typedef struct packed {
        logic shift;   // drop the front candidate, every cell takes its right neighbor
        logic append;  // a request is taken: drop smaller back candidates, append sample
        logic clear;   // first sample of a series: treat every cell as empty
    } swm_ctrl_t;

endpackage

[src/swm_cell.sv]
// One slot of the monotonic candidate queue: value, position and valid bit.
// Depends on swm_pkg for the sample width and the control struct.
module swm_cell #(
    parameter int POS_W = 7,
    parameter bit HEAD  = 1'b0
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  swm_pkg::swm_ctrl_t                   ctrl,
    input  logic signed [swm_pkg::SAMPLE_W-1:0]  sample,
    input  logic [POS_W-1:0]                     cur_pos,
    input  logic                                 left_keep,
    input  logic                                 right_keep,
    input  logic signed [swm_pkg::SAMPLE_W-1:0]  right_value,
    input  logic [POS_W-1:0]                     right_pos,
    output logic                                 valid,
    output logic signed [swm_pkg::SAMPLE_W-1:0]  value,
    output logic [POS_W-1:0]                     pos,
    output logic                                 keep,
    output logic signed [swm_pkg::SAMPLE_W-1:0]  value_next
);
    import swm_pkg::*;

    logic                        valid_reg;
    logic                        valid_next;
    logic signed [SAMPLE_W-1:0]  value_reg;
    logic [POS_W-1:0]            pos_reg;
    logic [POS_W-1:0]            pos_next;
    logic                        valid_eff;
    logic                        keep_prev;
    logic                        keep_src;

    always_comb
    begin
        valid_eff = valid_reg & ~ctrl.clear;
        // Back candidates strictly smaller than the new sample are dropped.
        keep      = valid_eff & (~ctrl.append | ~(value_reg < sample));
        keep_prev = HEAD ? 1'b1 : (ctrl.shift ? keep : left_keep);
        keep_src  = ctrl.shift ? right_keep : keep;

        valid_next = keep_src | (ctrl.append & keep_prev);
        if (keep_src)
        begin
            value_next = ctrl.shift ? right_value : value_reg;
            pos_next   = ctrl.shift ? right_pos : pos_reg;
        end
        else
        begin
            value_next = sample;
            pos_next   = cur_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= value_next;
            pos_reg   <= pos_next;
        end
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign pos   = pos_reg;

endmodule

[src/sliding_window_maximum_unit.sv]
// Sliding-window maximum unit: top level with a chain of queue cells.
// window_max is registered and appears in the cycle after the sample request is accepted.
// Throughput: one sample per cycle while window_size is steady and out_ready keeps the output
// free; after window_size shrinks, the request is held while aged-out front candidates drop one per cycle.
// Reset clears the queue valid bits, position and sample counters; window_size resets to 1.
// Depends on swm_pkg and swm_cell.
module sliding_window_maximum_unit #(
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [swm_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                 first_of_series,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [swm_pkg::SAMPLE_W-1:0]  window_max,
    input  logic                                 cfg_write_en,
    input  logic [swm_pkg::WSIZE_W-1:0]          cfg_write_data
);
    import swm_pkg::*;

    // WW holds counts up to MAX_WINDOW; positions run modulo 2*MAX_WINDOW.
    localparam int WW      = $clog2(MAX_WINDOW + 1);
    localparam int PW      = $clog2(2 * MAX_WINDOW);
    localparam int POS_MOD = 2 * MAX_WINDOW;

    logic [WSIZE_W-1:0]  window_size_reg;
    logic [PW-1:0]       sp_reg;
    logic [PW-1:0]       sp_next;
    logic [WW-1:0]       seen_reg;
    logic [WW-1:0]       seen_next;
    logic                out_valid_reg;
    logic signed [SAMPLE_W-1:0] window_max_reg;

    logic [WW-1:0]       weff;
    logic [PW-1:0]       base_pos;
    logic [PW-1:0]       age0;
    logic [PW-1:0]       age1;
    logic                aged0;
    logic                aged1;
    logic                pop_cycle;
    logic                in_fire;
    logic                step_en;
    logic                has_result;
    swm_ctrl_t           ctrl;

    // Cell chain, one extra slot past the tail that reads as empty.
    logic                        cell_valid [MAX_WINDOW];
    logic signed [SAMPLE_W-1:0]  cell_value [MAX_WINDOW+1];
    logic [PW-1:0]               cell_pos   [MAX_WINDOW+1];
    logic                        cell_keep  [MAX_WINDOW+1];
    logic signed [SAMPLE_W-1:0]  cell_vnext [MAX_WINDOW];

    // Distance in positions, modulo 2*MAX_WINDOW.
    function automatic logic [PW-1:0] pos_age(input logic [PW-1:0] now,
                                              input logic [PW-1:0] then_pos);
        logic [PW:0] sum;
        begin
            sum = {1'b0, now} - {1'b0, then_pos};
            if (now < then_pos)
            begin
                sum = sum + (PW+1)'(POS_MOD);
            end
            pos_age = sum[PW-1:0];
        end
    endfunction

    // Clamp the window register: zero acts as one, large values saturate.
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            weff = WW'(1);
        end
        else if (32'(window_size_reg) > MAX_WINDOW)
        begin
            weff = WW'(MAX_WINDOW);
        end
        else
        begin
            weff = WW'(window_size_reg);
        end
    end

    // Ageing looks at the two front cells only: entries sit in position order,
    // so if the second is aged the front is too and another drop cycle follows.
    always_comb
    begin
        age0  = pos_age(sp_reg, cell_pos[0]);
        age1  = pos_age(sp_reg, cell_pos[1]);
        aged0 = cell_valid[0] && (age0 >= PW'(weff));
        aged1 = cell_valid[1] && (age1 >= PW'(weff));
    end

    // Hold the pending request while more than one front candidate must go;
    // drop one per cycle. A new series clears the queue, so it never waits for front drops.
    assign pop_cycle = in_valid && !first_of_series && aged1;
    assign in_ready  = !(aged1 && !first_of_series) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign step_en   = in_fire || pop_cycle;

    always_comb
    begin
        ctrl.clear  = in_fire && first_of_series;
        ctrl.append = in_fire;
        ctrl.shift  = aged0 && !ctrl.clear;
    end

    // Position and fill counters for the sample being taken.
    always_comb
    begin
        base_pos = first_of_series ? '0 : sp_reg;
        if (base_pos == PW'(POS_MOD - 1))
        begin
            sp_next = '0;
        end
        else
        begin
            sp_next = base_pos + PW'(1);
        end

        if (first_of_series)
        begin
            seen_next = WW'(1);
        end
        else if (seen_reg < WW'(MAX_WINDOW))
        begin
            seen_next = seen_reg + WW'(1);
        end
        else
        begin
            seen_next = seen_reg;
        end
        has_result = (seen_next >= weff);
    end

    assign cell_keep[MAX_WINDOW]  = 1'b0;
    assign cell_value[MAX_WINDOW] = '0;
    assign cell_pos[MAX_WINDOW]   = '0;

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        logic left_keep;
        if (i == 0)
        begin : g_head
            assign left_keep = 1'b1;
        end
        else
        begin : g_body
            assign left_keep = cell_keep[i-1];
        end

        swm_cell #(
            .POS_W (PW),
            .HEAD  (i == 0)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .en          (step_en),
            .ctrl        (ctrl),
            .sample      (sample),
            .cur_pos     (base_pos),
            .left_keep   (left_keep),
            .right_keep  (cell_keep[i+1]),
            .right_value (cell_value[i+1]),
            .right_pos   (cell_pos[i+1]),
            .valid       (cell_valid[i]),
            .value       (cell_value[i]),
            .pos         (cell_pos[i]),
            .keep        (cell_keep[i]),
            .value_next  (cell_vnext[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WSIZE_W'(1);
            sp_reg          <= '0;
            seen_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                window_size_reg <= cfg_write_data;
            end
            if (in_fire)
            begin
                sp_reg   <= sp_next;
                seen_reg <= seen_next;
            end
            // Advance the output register: a new result replaces a taken one.
            if (in_fire && has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The front cell's next value is the window maximum.
    always_ff @(posedge clk)
    begin
        if (in_fire && has_result)
        begin
            window_max_reg <= cell_vnext[0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign window_max = window_max_reg;

    // Queue occupancy is a prefix of the chain.
    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[1] |-> cell_valid[0])
        else $error("queue has a hole at the front");

    // Candidates stay non-increasing from front to back.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[1] |-> (cell_value[0] >= cell_value[1]))
        else $error("queue lost its ordering");

    // A taken sample always leaves at least the front candidate behind.
    a_front: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> cell_valid[0])
        else $error("queue empty after a sample");

endmodule
